FILE: rtl/core/umlaut_digraph_input_transform_macros.svh
// assertion macros shared by the umlaut digraph transform rtl
`ifndef UMLAUT_DIGRAPH_INPUT_TRANSFORM_MACROS_SVH
`define UMLAUT_DIGRAPH_INPUT_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
// concurrent check on clk_i, masked while rst_ni is low
`define UDIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// concurrent check on clk_i that also holds during reset
`define UDIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UDIT_ASSERT(lbl, prop, msg)
`define UDIT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/udit_pkg.sv
// types, codes and digraph tables for the umlaut digraph transform
package udit_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned RuleW    = 3;
  localparam int unsigned NumRules = 7;

  typedef logic [CpW-1:0]   cp_t;
  typedef logic [RuleW-1:0] rule_t;

  // rule codes
  localparam rule_t RULE_NONE = 3'd0;
  localparam rule_t RULE_AE   = 3'd1;
  localparam rule_t RULE_OE   = 3'd2;
  localparam rule_t RULE_UE   = 3'd3;
  localparam rule_t RULE_CAE  = 3'd4;
  localparam rule_t RULE_COE  = 3'd5;
  localparam rule_t RULE_CUE  = 3'd6;
  localparam rule_t RULE_SZ   = 3'd7;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_BKSP  = 2'd1,
    OP_INVAL = 2'd2,
    OP_RESET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_PREFIX = 2'd1,
    ST_CONV   = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    ACT_PASS      = 2'd0,
    ACT_REPL_PREV = 2'd1,
    ACT_REPL_CONV = 2'd2
  } action_e;

  // engine state plus one-deep checkpoint
  typedef struct packed {
    stage_e stage;
    rule_t  rule;
    logic   ckpt_valid;
    stage_e ckpt_stage;
    rule_t  ckpt_rule;
  } state_t;

  // one result transaction
  typedef struct packed {
    action_e    action;
    logic [1:0] repl_len;
    cp_t        repl_char0;
    cp_t        repl_char1;
    logic       restored;
  } result_t;

  // letter that opens a digraph
  function automatic cp_t rule_first(rule_t r);
    cp_t c;
    case (r)
      RULE_AE:  c = CpW'(32'h61);
      RULE_OE:  c = CpW'(32'h6F);
      RULE_UE:  c = CpW'(32'h75);
      RULE_CAE: c = CpW'(32'h41);
      RULE_COE: c = CpW'(32'h4F);
      RULE_CUE: c = CpW'(32'h55);
      RULE_SZ:  c = CpW'(32'h73);
      default:  c = '0;
    endcase
    return c;
  endfunction

  // letter that completes a digraph
  function automatic cp_t rule_second(rule_t r);
    cp_t c;
    case (r)
      RULE_NONE: c = '0;
      RULE_SZ:   c = CpW'(32'h7A);
      default:   c = CpW'(32'h65);
    endcase
    return c;
  endfunction

  // converted codepoint
  function automatic cp_t rule_conv(rule_t r);
    cp_t c;
    case (r)
      RULE_AE:  c = CpW'(32'hE4);
      RULE_OE:  c = CpW'(32'hF6);
      RULE_UE:  c = CpW'(32'hFC);
      RULE_CAE: c = CpW'(32'hC4);
      RULE_COE: c = CpW'(32'hD6);
      RULE_CUE: c = CpW'(32'hDC);
      RULE_SZ:  c = CpW'(32'hDF);
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/umlaut_digraph_input_transform.sv
// top level of the umlaut digraph input transform
// Takes one key event per transaction and returns exactly one result per event.
// An event is accepted in any cycle in which the output register is empty or is
// being emptied, so the sustained rate is one event per clock; the result shows
// up in the output register in the cycle after acceptance. All work for an event
// is a single pass of compare logic (seven parallel prefix compares and one
// suffix compare) from the input port and engine state into that register.
// Writing eszett_enable also returns the engine to idle; the checkpoint stays.
`include "umlaut_digraph_input_transform_macros.svh"

module umlaut_digraph_input_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // key event input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [20:0] char_code_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [1:0]  repl_len_o,
  output logic [20:0] repl_char0_o,
  output logic [20:0] repl_char1_o,
  output logic        restored_o
);

  udit_pkg::state_t  state_q, state_d;
  udit_pkg::state_t  eng_nxt;
  udit_pkg::result_t eng_res;
  udit_pkg::result_t res_q;
  logic              eszett_q;
  logic              out_valid_q;
  logic              in_fire;
  logic              cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  udit_engine u_engine (
    .cur_i           (state_q),
    .opcode_i        (opcode_i),
    .char_code_i     (char_code_i),
    .eszett_enable_i (eszett_q),
    .nxt_o           (eng_nxt),
    .res_o           (eng_res)
  );

  // engine state next value
  always_comb begin
    state_d = state_q;
    if (cfg_fire) begin
      state_d.stage = udit_pkg::ST_IDLE;
      state_d.rule  = udit_pkg::RULE_NONE;
    end else if (in_fire) begin
      state_d = eng_nxt;
    end
  end

  // engine state and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage      <= udit_pkg::ST_IDLE;
      state_q.rule       <= udit_pkg::RULE_NONE;
      state_q.ckpt_valid <= 1'b0;
      state_q.ckpt_stage <= udit_pkg::ST_IDLE;
      state_q.ckpt_rule  <= udit_pkg::RULE_NONE;
      eszett_q           <= 1'b1;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        eszett_q <= cfg_data_i;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= eng_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = res_q.action;
  assign repl_len_o   = res_q.repl_len;
  assign repl_char0_o = res_q.repl_char0;
  assign repl_char1_o = res_q.repl_char1;
  assign restored_o   = res_q.restored;

  // checks
  `UDIT_ASSERT(a_idle_no_rule,
    (state_q.stage == udit_pkg::ST_IDLE) == (state_q.rule == udit_pkg::RULE_NONE),
    "engine idle state and active rule disagree")
  `UDIT_ASSERT(a_ckpt_is_prefix,
    state_q.ckpt_valid |-> (state_q.ckpt_stage == udit_pkg::ST_PREFIX &&
                            state_q.ckpt_rule != udit_pkg::RULE_NONE),
    "checkpoint holds something other than a pending prefix")
  `UDIT_ASSERT(a_restore_to_prefix,
    in_fire && opcode_i == udit_pkg::OP_BKSP && state_q.ckpt_valid && !cfg_fire
      |=> state_q.stage == udit_pkg::ST_PREFIX && !state_q.ckpt_valid && restored_o,
    "backspace with checkpoint did not restore the prefix")
  `UDIT_ASSERT(a_restored_is_pass,
    out_valid_o && restored_o |-> action_o == udit_pkg::ACT_PASS && repl_len_o == 2'd0,
    "restored result carries a replacement")
  `UDIT_ASSERT(a_repl_prev_len,
    out_valid_o && action_o == udit_pkg::ACT_REPL_PREV |-> repl_len_o == 2'd1,
    "umlaut replacement with wrong length")

endmodule

FILE: rtl/core/udit_engine.sv
// next-state and result logic for one key event
module udit_engine (
  input  udit_pkg::state_t  cur_i,
  input  logic [1:0]        opcode_i,
  input  udit_pkg::cp_t     char_code_i,
  input  logic              eszett_enable_i,
  output udit_pkg::state_t  nxt_o,
  output udit_pkg::result_t res_o
);

  udit_pkg::op_e   op;
  udit_pkg::rule_t pfx_rule;
  logic            rule_ok;
  logic            second_hit;

  assign op         = udit_pkg::op_e'(opcode_i);
  assign rule_ok    = (cur_i.rule != udit_pkg::RULE_NONE);
  assign second_hit = rule_ok && (char_code_i == udit_pkg::rule_second(cur_i.rule));

  // parallel prefix compare, lowest rule wins
  always_comb begin
    pfx_rule = udit_pkg::RULE_NONE;
    for (int i = udit_pkg::NumRules; i >= 1; i--) begin
      if ((udit_pkg::RuleW'(i) != udit_pkg::RULE_SZ || eszett_enable_i) &&
          char_code_i == udit_pkg::rule_first(udit_pkg::RuleW'(i))) begin
        pfx_rule = udit_pkg::RuleW'(i);
      end
    end
  end

  // state update and result
  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    res_o.action = udit_pkg::ACT_PASS;
    case (op)
      udit_pkg::OP_PRINT: begin
        // checkpoint a pending prefix before the letter is applied
        nxt_o.ckpt_valid = (cur_i.stage == udit_pkg::ST_PREFIX);
        if (cur_i.stage == udit_pkg::ST_PREFIX) begin
          nxt_o.ckpt_stage = cur_i.stage;
          nxt_o.ckpt_rule  = cur_i.rule;
        end
        if (cur_i.stage == udit_pkg::ST_CONV && second_hit) begin
          // undo: converted char back to escaped text
          res_o.action     = udit_pkg::ACT_REPL_CONV;
          res_o.repl_len   = 2'd2;
          res_o.repl_char0 = udit_pkg::rule_first(cur_i.rule);
          res_o.repl_char1 = udit_pkg::rule_second(cur_i.rule);
          nxt_o.stage      = udit_pkg::ST_IDLE;
          nxt_o.rule       = udit_pkg::RULE_NONE;
          nxt_o.ckpt_valid = 1'b0;
        end else if (cur_i.stage == udit_pkg::ST_PREFIX && second_hit) begin
          // digraph complete: replace prefix with umlaut
          res_o.action     = udit_pkg::ACT_REPL_PREV;
          res_o.repl_len   = 2'd1;
          res_o.repl_char0 = udit_pkg::rule_conv(cur_i.rule);
          nxt_o.stage      = udit_pkg::ST_CONV;
          nxt_o.ckpt_valid = 1'b0;
        end else begin
          nxt_o.rule  = pfx_rule;
          nxt_o.stage = (pfx_rule != udit_pkg::RULE_NONE) ? udit_pkg::ST_PREFIX
                                                          : udit_pkg::ST_IDLE;
        end
      end
      udit_pkg::OP_BKSP: begin
        if (cur_i.ckpt_valid) begin
          nxt_o.stage      = cur_i.ckpt_stage;
          nxt_o.rule       = cur_i.ckpt_rule;
          nxt_o.ckpt_valid = 1'b0;
          res_o.restored   = 1'b1;
        end
      end
      udit_pkg::OP_INVAL: begin
        nxt_o.ckpt_valid = 1'b0;
      end
      udit_pkg::OP_RESET: begin
        nxt_o.stage = udit_pkg::ST_IDLE;
        nxt_o.rule  = udit_pkg::RULE_NONE;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

FILE: verif/umlaut_digraph_input_transform_checker.sv
// channel monitor, result predictor and comparator for the umlaut digraph transform
`timescale 1ns / 100ps

module umlaut_digraph_input_transform_checker
  import udit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  logic [20:0] char_code_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  action_i,
  input  logic [1:0]  repl_len_i,
  input  logic [20:0] repl_char0_i,
  input  logic [20:0] repl_char1_i,
  input  logic        restored_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  // predicted engine state and checkpoint
  logic    sharp_s_en;
  stage_e  cur_stage;
  rule_t   cur_rule;
  logic    hold_valid;
  stage_e  hold_stage;
  rule_t   hold_rule;

  result_t     want_q[$];
  int unsigned errors;

  // rule opened by a typed letter
  function automatic rule_t lead_rule(cp_t ch);
    case (ch)
      cp_t'("a"): return RULE_AE;
      cp_t'("o"): return RULE_OE;
      cp_t'("u"): return RULE_UE;
      cp_t'("A"): return RULE_CAE;
      cp_t'("O"): return RULE_COE;
      cp_t'("U"): return RULE_CUE;
      cp_t'("s"): return sharp_s_en ? RULE_SZ : RULE_NONE;
      default:    return RULE_NONE;
    endcase
  endfunction

  // letter that opened a rule, used for the escaped text
  function automatic cp_t lead_letter(rule_t r);
    case (r)
      RULE_AE:  return cp_t'("a");
      RULE_OE:  return cp_t'("o");
      RULE_UE:  return cp_t'("u");
      RULE_CAE: return cp_t'("A");
      RULE_COE: return cp_t'("O");
      RULE_CUE: return cp_t'("U");
      default:  return cp_t'("s");
    endcase
  endfunction

  function automatic cp_t umlaut_of(rule_t r);
    case (r)
      RULE_AE:  return cp_t'('hE4);
      RULE_OE:  return cp_t'('hF6);
      RULE_UE:  return cp_t'('hFC);
      RULE_CAE: return cp_t'('hC4);
      RULE_COE: return cp_t'('hD6);
      RULE_CUE: return cp_t'('hDC);
      default:  return cp_t'('hDF);
    endcase
  endfunction

  // advance the predicted engine by one key event and return its result
  function automatic result_t transform_key(op_e op, cp_t ch);
    result_t r;
    logic    rule_ok;
    cp_t     tail;
    r       = '0;
    rule_ok = (cur_rule != RULE_NONE);
    tail    = (cur_rule == RULE_SZ) ? cp_t'("z") : cp_t'("e");
    case (op)
      OP_PRINT: begin
        // checkpoint only a pending prefix
        hold_valid = (cur_stage == ST_PREFIX);
        if (hold_valid) begin
          hold_stage = cur_stage;
          hold_rule  = cur_rule;
        end
        if (rule_ok && cur_stage == ST_CONV && ch == tail) begin
          // second letter again: undo into escaped text
          r.action     = ACT_REPL_CONV;
          r.repl_len   = 2'd2;
          r.repl_char0 = lead_letter(cur_rule);
          r.repl_char1 = tail;
          cur_stage    = ST_IDLE;
          cur_rule     = RULE_NONE;
          hold_valid   = 1'b0;
        end else if (rule_ok && cur_stage == ST_PREFIX && ch == tail) begin
          r.action     = ACT_REPL_PREV;
          r.repl_len   = 2'd1;
          r.repl_char0 = umlaut_of(cur_rule);
          cur_stage    = ST_CONV;
          hold_valid   = 1'b0;
        end else begin
          cur_rule  = lead_rule(ch);
          cur_stage = (cur_rule != RULE_NONE) ? ST_PREFIX : ST_IDLE;
        end
      end
      OP_BKSP: begin
        if (hold_valid) begin
          cur_stage  = hold_stage;
          cur_rule   = hold_rule;
          hold_valid = 1'b0;
          r.restored = 1'b1;
        end
      end
      OP_INVAL: hold_valid = 1'b0;
      default: begin
        cur_stage = ST_IDLE;
        cur_rule  = RULE_NONE;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string fld, logic [20:0] exp_v, logic [20:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
      errors++;
    end
  endtask

  // track config, input and result transactions
  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      sharp_s_en  = 1'b1;
      cur_stage   = ST_IDLE;
      cur_rule    = RULE_NONE;
      hold_valid  = 1'b0;
      hold_stage  = ST_IDLE;
      hold_rule   = RULE_NONE;
      errors      = 0;
      want_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      // register write also returns the engine to idle
      if (cfg_valid_i && cfg_ready_i) begin
        sharp_s_en = cfg_data_i;
        cur_stage  = ST_IDLE;
        cur_rule   = RULE_NONE;
      end
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got action %0h len %0h",
                   $time, action_i, repl_len_i);
          errors++;
        end else begin
          want = want_q.pop_front();
          check_field("action", 21'(want.action), 21'(action_i));
          check_field("repl_len", 21'(want.repl_len), 21'(repl_len_i));
          check_field("repl_char0", want.repl_char0, repl_char0_i);
          check_field("repl_char1", want.repl_char1, repl_char1_i);
          check_field("restored", 21'(want.restored), 21'(restored_i));
        end
      end
      if (in_valid_i && in_ready_i)
        want_q.push_back(transform_key(op_e'(opcode_i), char_code_i));
      err_count_o <= errors;
      pending_o   <= want_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
// stimulus and verdict for the umlaut digraph transform testbench
`timescale 1ns / 100ps

module tb;
  import udit_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_data_i  = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  opcode_i    = OP_PRINT;
  logic [20:0] char_code_i = '0;
  logic        out_ready_i = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  action_o;
  logic [1:0]  repl_len_o;
  logic [20:0] repl_char0_o;
  logic [20:0] repl_char1_o;
  logic        restored_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned keys_sent = 0;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 86;

  string leads = "aouAOUs";
  string letter_pool = "aouAOUszeEx";

  umlaut_digraph_input_transform uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_o     (action_o),
    .repl_len_o   (repl_len_o),
    .repl_char0_o (repl_char0_o),
    .repl_char1_o (repl_char1_o),
    .restored_o   (restored_o)
  );

  umlaut_digraph_input_transform_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_i     (action_o),
    .repl_len_i   (repl_len_o),
    .repl_char0_i (repl_char0_o),
    .repl_char1_i (repl_char1_o),
    .restored_i   (restored_o),
    .err_count_o  (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic cp_t rand_cp();
    return cp_t'($urandom_range(21'h10FFFF));
  endfunction

  // interesting letters half of the time, otherwise any codepoint
  function automatic cp_t any_char();
    if ($urandom_range(1))
      return cp_t'(letter_pool[$urandom_range(letter_pool.len() - 1)]);
    return rand_cp();
  endfunction

  // one key event transaction, with random sender gaps before it
  task automatic press(op_e op, cp_t ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    char_code_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    keys_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic sharp_s);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sharp_s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // random typing: digraph sequences in 45 of every 100 picks, the rest noise and edits
  task automatic random_keys(int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned li;
    cp_t lead;
    cp_t tail;
    goal = keys_sent + count;
    while (keys_sent < goal) begin
      pick = $urandom_range(99);
      li   = $urandom_range(6);
      lead = cp_t'(leads[li]);
      tail = (li == 6) ? cp_t'("z") : cp_t'("e");
      if (pick < 45) begin
        press(OP_PRINT, lead);
        press(OP_PRINT, tail);
        if ($urandom_range(1)) press(OP_PRINT, tail);
        if ($urandom_range(3) == 0) press(OP_PRINT, tail);
      end else if (pick < 60) begin
        // backspace over a stray letter brings the prefix back
        press(OP_PRINT, lead);
        press(OP_PRINT, any_char());
        press(OP_BKSP, rand_cp());
        if ($urandom_range(3) != 0) press(OP_PRINT, tail);
      end else if (pick < 68) begin
        press(OP_PRINT, lead);
        press(OP_PRINT, any_char());
        press($urandom_range(1) ? OP_INVAL : OP_RESET, rand_cp());
        press(OP_BKSP, rand_cp());
        press(OP_PRINT, tail);
      end else if (pick < 85) begin
        press(OP_PRINT, any_char());
      end else begin
        press(op_e'($urandom_range(3, 1)), rand_cp());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each digraph path, escape, restore, invalidate, reset, extremes
    press(OP_PRINT, "a");
    press(OP_PRINT, "e");
    press(OP_PRINT, "e");
    press(OP_PRINT, "O");
    press(OP_PRINT, "e");
    press(OP_PRINT, "s");
    press(OP_PRINT, "z");
    press(OP_PRINT, "z");
    press(OP_BKSP, '0);
    press(OP_PRINT, "u");
    press(OP_PRINT, "x");
    press(OP_BKSP, '0);
    press(OP_PRINT, "e");
    press(OP_PRINT, "a");
    press(OP_PRINT, "x");
    press(OP_INVAL, '0);
    press(OP_BKSP, 21'h10FFFF);
    press(OP_PRINT, "A");
    press(OP_RESET, 21'h10FFFF);
    press(OP_PRINT, "e");
    press(OP_PRINT, '0);
    press(OP_PRINT, 21'h10FFFF);
    // sz prefix restored after sharp s is disabled still completes
    press(OP_PRINT, "s");
    press(OP_PRINT, "x");
    settle();
    write_cfg(1'b0);
    press(OP_BKSP, '0);
    press(OP_PRINT, "z");
    press(OP_PRINT, "s");
    press(OP_PRINT, "z");
    settle();

    // slow sender, heavily stalled receiver
    random_keys(360);
    settle();
    write_cfg(1'b1);

    // heavily idle sender, lightly stalled receiver
    send_idle_pct = 86;
    recv_idle_pct = 37;
    random_keys(360);
    settle();
    write_cfg(1'b0);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_keys(180);
    settle();
    write_cfg(1'b1);
    random_keys(180);
    settle();

    if (fail_count == 0)
      $display("umlaut_digraph_input_transform test passed");
    else
      $display("umlaut_digraph_input_transform test failed");
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("umlaut_digraph_input_transform test failed");
    $finish;
  end

endmodule
